// ===== rtl/alfu_pkg.sv =====
package alfu_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_COUNT_BITS = 16;

  // Fixed field widths of the request and result payloads.
  localparam int KEY_W    = 32;
  localparam int USE_W    = 16;
  localparam int OCC_W    = 7;
  localparam int LIMIT_W  = 7;
  localparam int PERIOD_W = 16;

  // Configuration port geometry and register reset values.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(64);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2000);

  // Register indexes, taken from the word address.
  typedef enum logic {
    REG_LIMIT  = 1'b0,
    REG_PERIOD = 1'b1
  } cfg_reg_t;

  // Request kinds.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] lookup_key;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             stored;
    logic [USE_W-1:0] use_count;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_LK_DONE,
    ST_TICK,
    ST_NO_EVICT,
    ST_DECAY,
    ST_EV_CHECK,
    ST_EV_SCAN,
    ST_EVICT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic req_load;
    logic scan_start;
    logic scan_run;
    logic decay_wr;
    logic lookup_commit;
    logic tick_step;
    logic emit_none;
    logic evict_commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_end;
    logic hit_found;
    logic scan_done;
    logic clean_due;
    logic over_limit;
    logic evict_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/aging_lfu_key_cache_core.sv =====
// Aging LFU key cache: a table of CAPACITY keys with saturating use counts.
// A lookup request returns one result: hit with the incremented count, a
// miss stored with count 1 in the lowest free slot, or a miss not stored
// when the table is full. A tick request advances a period counter; on the
// tick that reaches clean_period every nonzero count drops by one and the
// entries with the lowest counts (lowest slot on ties) are evicted until at
// most occupancy_limit remain, one result per eviction with last on the
// final one, or a single empty result when nothing is evicted. Keys and
// counts live in stores with one write port and one read port, scanned one
// entry per cycle. A lookup scan stops early when it hits. A cleaning pass
// runs a decrement sweep over the table and the limit check, then one scan
// for the lowest count per eviction. A stalled result holds up the next
// step until it is taken. After reset a clearing pass over the count store
// runs before the first request is taken; configuration writes are accepted
// throughout.
module aging_lfu_key_cache_core #(
  parameter int CAPACITY   = alfu_pkg::DEF_CAPACITY,
  parameter int COUNT_BITS = alfu_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  alfu_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output alfu_pkg::rsp_t                     rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [alfu_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [alfu_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [alfu_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  import alfu_pkg::*;

  logic [LIMIT_W-1:0]  occupancy_limit;
  logic [PERIOD_W-1:0] clean_period;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;
  cmd_t                cmd;
  status_t             st;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy_limit <= LIMIT_RESET;
      clean_period    <= PERIOD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LIMIT:  occupancy_limit <= pwdata[LIMIT_W-1:0];
        REG_PERIOD: clean_period    <= pwdata[PERIOD_W-1:0];
        default:    occupancy_limit <= occupancy_limit;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_sel)
      REG_LIMIT:  prdata = APB_DATA_W'(occupancy_limit);
      REG_PERIOD: prdata = APB_DATA_W'(clean_period);
      default:    prdata = '0;
    endcase
  end

  alfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .st        (st),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  alfu_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req             (req),
    .occupancy_limit (occupancy_limit),
    .clean_period    (clean_period),
    .rsp_stall       (rsp_stall),
    .rsp_valid       (rsp_valid),
    .rsp             (rsp),
    .st              (st)
  );

`ifndef SYNTHESIS
  // An eviction result never reports a lookup outcome.
  a_evict_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> !rsp.hit && !rsp.stored)
    else $error("eviction result carries lookup flags");

  // A newly stored entry always starts with a count of one.
  a_stored_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stored |-> rsp.use_count == USE_W'(1) && !rsp.hit)
    else $error("stored result with wrong count");

  // The final eviction of a pass leaves the table within the limit.
  a_evict_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.evict_commit |=> !rsp.last || !st.over_limit)
    else $error("eviction pass ended above the occupancy limit");
`endif

endmodule

// ===== rtl/alfu_ctrl.sv =====
module alfu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_kind,
  input  alfu_pkg::status_t st,
  output logic             req_stall,
  output alfu_pkg::cmd_t    cmd
);

  import alfu_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the count store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (st.clear_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_kind == KIND_TICK) ? ST_TICK : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (st.hit_found || st.scan_done) state_next = ST_LK_DONE;
      end
      ST_LK_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_TICK: begin
        state_next = st.clean_due ? ST_DECAY : ST_NO_EVICT;
      end
      ST_NO_EVICT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_DECAY: begin
        if (st.scan_done) state_next = ST_EV_CHECK;
      end
      ST_EV_CHECK: begin
        state_next = st.over_limit ? ST_EV_SCAN : ST_NO_EVICT;
      end
      ST_EV_SCAN: begin
        if (st.scan_done) state_next = ST_EVICT;
      end
      ST_EVICT: begin
        if (st.out_free) state_next = st.evict_last ? ST_IDLE : ST_EV_SCAN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    req_stall = 1'b1;
    cmd       = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        req_stall      = 1'b0;
        cmd.req_load   = req_valid;
        cmd.scan_start = req_valid;
      end
      ST_LOOKUP: begin
        cmd.scan_run = 1'b1;
      end
      ST_LK_DONE: begin
        cmd.lookup_commit = st.out_free;
      end
      ST_TICK: begin
        cmd.tick_step  = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_NO_EVICT: begin
        cmd.emit_none = st.out_free;
      end
      ST_DECAY: begin
        cmd.scan_run = 1'b1;
        cmd.decay_wr = 1'b1;
      end
      ST_EV_CHECK: begin
        cmd.scan_start = 1'b1;
      end
      ST_EV_SCAN: begin
        cmd.scan_run = 1'b1;
      end
      ST_EVICT: begin
        cmd.evict_commit = st.out_free;
        cmd.scan_start   = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/alfu_dp.sv =====
module alfu_dp #(
  parameter int CAPACITY   = alfu_pkg::DEF_CAPACITY,
  parameter int COUNT_BITS = alfu_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  alfu_pkg::cmd_t                  cmd,
  input  alfu_pkg::req_t                  req,
  input  logic [alfu_pkg::LIMIT_W-1:0]    occupancy_limit,
  input  logic [alfu_pkg::PERIOD_W-1:0]   clean_period,
  input  logic                            rsp_stall,
  output logic                            rsp_valid,
  output alfu_pkg::rsp_t                  rsp,
  output alfu_pkg::status_t               st
);

  import alfu_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int SCAN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (SCAN_W > LIMIT_W) ? SCAN_W : LIMIT_W;
  localparam int UCW    = (COUNT_BITS > USE_W) ? COUNT_BITS : USE_W;
  localparam int META_W = COUNT_BITS + 1;

  // Key store and count store (valid bit on top of the count).
  logic [KEY_W-1:0]  key_mem  [CAPACITY];
  logic [META_W-1:0] meta_mem [CAPACITY];

  logic [KEY_W-1:0]      key_q;
  logic [META_W-1:0]     meta_q;
  logic                  q_valid;
  logic [COUNT_BITS-1:0] q_count;

  logic [SCAN_W-1:0] scan_addr;
  logic              scan_at_end;
  logic              rd_en;
  logic              rd_pending;
  logic [IDX_W-1:0]  rd_idx;

  logic                  key_we;
  logic [IDX_W-1:0]      key_waddr;
  logic                  meta_we;
  logic [IDX_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;

  logic [KEY_W-1:0]      req_key;

  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] hit_count_inc;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  min_found;
  logic [IDX_W-1:0]      min_idx;
  logic [COUNT_BITS-1:0] min_count;
  logic [KEY_W-1:0]      min_key;

  logic [SCAN_W-1:0]     valid_total;
  logic [SCAN_W-1:0]     valid_dec;
  logic [PERIOD_W-1:0]   tick_counter;
  logic [PERIOD_W-1:0]   tick_inc;
  logic                  out_free;
  logic                  insert;
  rsp_t                  rsp_next;

  // Low bits of an occupancy value, whatever the table size.
  function automatic logic [OCC_W-1:0] occ_of(input logic [SCAN_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return w[OCC_W-1:0];
  endfunction

  // Low bits of a use count, whatever the counter width.
  function automatic logic [USE_W-1:0] use_of(input logic [COUNT_BITS-1:0] c);
    logic [UCW-1:0] w;
    w = UCW'(c);
    return w[USE_W-1:0];
  endfunction

  assign q_valid = meta_q[COUNT_BITS];
  assign q_count = meta_q[COUNT_BITS-1:0];

  assign scan_at_end = (scan_addr == SCAN_W'(CAPACITY));
  assign rd_en       = cmd.scan_run && !scan_at_end;

  // Scan address counter; one entry is read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      rd_pending <= 1'b0;
    end else if (cmd.clear_step) begin
      scan_addr  <= scan_addr + SCAN_W'(1);
      rd_pending <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_addr  <= '0;
      rd_pending <= 1'b0;
    end else if (rd_en) begin
      scan_addr  <= scan_addr + SCAN_W'(1);
      rd_pending <= 1'b1;
    end else begin
      rd_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_idx <= scan_addr[IDX_W-1:0];
  end

  // Key store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= req_key;
    if (rd_en) key_q <= key_mem[scan_addr[IDX_W-1:0]];
  end

  // Count store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (rd_en) meta_q <= meta_mem[scan_addr[IDX_W-1:0]];
  end

  assign hit_count_inc = (&hit_count) ? hit_count : hit_count + COUNT_BITS'(1);
  assign insert        = !hit_found && free_found;

  // Write selection for both stores.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = rd_idx;
    meta_wdata = '0;
    key_we     = 1'b0;
    key_waddr  = free_idx;
    priority if (cmd.clear_step) begin
      meta_we    = 1'b1;
      meta_waddr = scan_addr[IDX_W-1:0];
    end else if (cmd.decay_wr && rd_pending) begin
      meta_we    = 1'b1;
      meta_waddr = rd_idx;
      meta_wdata = {q_valid, (q_valid && (q_count != '0)) ?
                             q_count - COUNT_BITS'(1) : q_count};
    end else if (cmd.lookup_commit && hit_found) begin
      meta_we    = 1'b1;
      meta_waddr = hit_idx;
      meta_wdata = {1'b1, hit_count_inc};
    end else if (cmd.lookup_commit && insert) begin
      meta_we    = 1'b1;
      meta_waddr = free_idx;
      meta_wdata = {1'b1, COUNT_BITS'(1)};
      key_we     = 1'b1;
    end else if (cmd.evict_commit) begin
      meta_we    = 1'b1;
      meta_waddr = min_idx;
    end else begin
      meta_we = 1'b0;
    end
  end

  // Key of the request under work.
  always_ff @(posedge clk) begin
    if (cmd.req_load) req_key <= req.lookup_key;
  end

  // Scan trackers: first match, first free slot and lowest count.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      min_found  <= 1'b0;
    end else if (rd_pending) begin
      if (q_valid && (key_q == req_key) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_count <= q_count;
      end
      if (!q_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (q_valid && (!min_found || (q_count < min_count))) begin
        min_found <= 1'b1;
        min_idx   <= rd_idx;
        min_count <= q_count;
        min_key   <= key_q;
      end
    end
  end

  assign valid_dec = valid_total - SCAN_W'(1);

  // Occupancy counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_total <= '0;
    end else if (cmd.lookup_commit && insert) begin
      valid_total <= valid_total + SCAN_W'(1);
    end else if (cmd.evict_commit) begin
      valid_total <= valid_dec;
    end
  end

  // Period counter.
  assign tick_inc = tick_counter + PERIOD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
    end else if (cmd.tick_step) begin
      tick_counter <= st.clean_due ? '0 : tick_inc;
    end
  end

  // Result payload for whichever result is being issued.
  always_comb begin
    rsp_next           = '0;
    rsp_next.last      = 1'b1;
    rsp_next.occupancy = occ_of(valid_total);
    if (cmd.lookup_commit) begin
      if (hit_found) begin
        rsp_next.hit       = 1'b1;
        rsp_next.use_count = use_of(hit_count_inc);
      end else if (free_found) begin
        rsp_next.stored    = 1'b1;
        rsp_next.use_count = USE_W'(1);
        rsp_next.occupancy = occ_of(valid_total + SCAN_W'(1));
      end
    end else if (cmd.evict_commit) begin
      rsp_next.evicted     = 1'b1;
      rsp_next.evicted_key = min_key;
      rsp_next.occupancy   = occ_of(valid_dec);
      rsp_next.last        = st.evict_last;
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.lookup_commit || cmd.emit_none || cmd.evict_commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_commit || cmd.emit_none || cmd.evict_commit) rsp <= rsp_next;
  end

  // Status to the controller.
  assign st.clear_end  = (scan_addr == SCAN_W'(CAPACITY - 1));
  assign st.hit_found  = hit_found;
  assign st.scan_done  = scan_at_end && !rd_pending;
  assign st.clean_due  = !(tick_inc < clean_period);
  assign st.over_limit = CMP_W'(valid_total) > CMP_W'(occupancy_limit);
  assign st.evict_last = !(CMP_W'(valid_dec) > CMP_W'(occupancy_limit));
  assign st.out_free   = out_free;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import alfu_pkg::*;

  localparam int CAP   = DEF_CAPACITY;
  localparam int CBITS = DEF_COUNT_BITS;
  localparam logic [CBITS-1:0] COUNT_TOP = '1;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req       = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  aging_lfu_key_cache_core #(
    .CAPACITY   (CAP),
    .COUNT_BITS (CBITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the cache table, counters and registers.
  logic [KEY_W-1:0]    tbl_key   [CAP];
  logic                tbl_valid [CAP];
  logic [CBITS-1:0]    tbl_count [CAP];
  logic [15:0]         tick_cnt = '0;
  int                  fill     = 0;
  logic [LIMIT_W-1:0]  limit_q  = LIMIT_RESET;
  logic [PERIOD_W-1:0] period_q = PERIOD_RESET;

  rsp_t             expected_q [$];
  logic [KEY_W-1:0] key_pool   [$];
  int               fail_count = 0;
  bit               idle_on    = 1'b1;
  int               stall_left = 0;

  initial begin
    for (int i = 0; i < CAP; i++) begin
      tbl_key[i]   = '0;
      tbl_valid[i] = 1'b0;
      tbl_count[i] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: the run must have finished long before this.
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void push_result(logic hit, logic stored, logic [USE_W-1:0] cnt,
                                      logic ev, logic [KEY_W-1:0] ev_key, logic last);
    rsp_t r;
    r.hit         = hit;
    r.stored      = stored;
    r.use_count   = cnt;
    r.evicted     = ev;
    r.evicted_key = ev_key;
    r.occupancy   = OCC_W'(fill);
    r.last        = last;
    expected_q.push_back(r);
  endfunction

  // A lookup hits and bumps the count, or stores the key in the lowest free slot.
  function automatic void predict_lookup(logic [KEY_W-1:0] key);
    int found;
    int free_slot;
    found     = -1;
    free_slot = -1;
    for (int i = 0; i < CAP; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && found < 0)
        found = i;
      if (!tbl_valid[i] && free_slot < 0)
        free_slot = i;
    end
    if (found >= 0) begin
      if (tbl_count[found] != COUNT_TOP)
        tbl_count[found]++;
      push_result(1'b1, 1'b0, USE_W'(tbl_count[found]), 1'b0, '0, 1'b1);
    end else if (free_slot < 0) begin
      push_result(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
    end else begin
      tbl_valid[free_slot] = 1'b1;
      tbl_key[free_slot]   = key;
      tbl_count[free_slot] = CBITS'(1);
      fill++;
      push_result(1'b0, 1'b1, USE_W'(1), 1'b0, '0, 1'b1);
    end
  endfunction

  // A tick ages the table once the period expires and evicts down to the limit.
  function automatic void predict_tick();
    int victim;
    int evictions;
    evictions = 0;
    tick_cnt  = tick_cnt + 16'd1;
    if (tick_cnt < period_q) begin
      push_result(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
      return;
    end
    tick_cnt = '0;
    for (int i = 0; i < CAP; i++)
      if (tbl_valid[i] && tbl_count[i] != '0)
        tbl_count[i]--;
    while (fill > int'(limit_q)) begin
      victim = -1;
      for (int i = 0; i < CAP; i++)
        if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim]))
          victim = i;
      if (victim < 0)
        break;
      tbl_valid[victim] = 1'b0;
      tbl_count[victim] = '0;
      fill--;
      push_result(1'b0, 1'b0, '0, 1'b1, tbl_key[victim], fill <= int'(limit_q));
      evictions++;
    end
    if (evictions == 0)
      push_result(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
  endfunction

  // Response stall: random runs, switched off when idling is disabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
      stall_left = rand_gap();
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("hit", 32'(want.hit), 32'(rsp.hit));
        check_field("stored", 32'(want.stored), 32'(rsp.stored));
        check_field("use_count", 32'(want.use_count), 32'(rsp.use_count));
        check_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
        check_field("evicted_key", want.evicted_key, rsp.evicted_key);
        check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
        check_field("last", 32'(want.last), 32'(rsp.last));
      end
    end
  end

  // Send one request; valid stays high when the next one follows at once.
  task automatic send_req(input logic kind, input logic [KEY_W-1:0] key);
    int   gap;
    req_t r;
    gap          = rand_gap();
    r.kind       = kind;
    r.lookup_key = key;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    if (kind == KIND_TICK)
      predict_tick();
    else
      predict_lookup(key);
  endtask

  // Hold off new requests until every expected result has arrived.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input cfg_reg_t idx,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input cfg_reg_t idx);
    logic [APB_DATA_W-1:0] got;
    logic [APB_DATA_W-1:0] want;
    apb_xfer(1'b0, idx, '0, got);
    want = (idx == REG_LIMIT) ? APB_DATA_W'(limit_q) : APB_DATA_W'(period_q);
    check_field(idx.name(), want, got);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    if (idx == REG_LIMIT)
      limit_q = LIMIT_W'(value);
    else
      period_q = PERIOD_W'(value);
    check_reg(idx);
  endtask

  task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic [PERIOD_W-1:0] period);
    drain_results();
    cfg_write(REG_LIMIT, APB_DATA_W'(limit));
    cfg_write(REG_PERIOD, APB_DATA_W'(period));
  endtask

  function automatic void build_pool(int size);
    key_pool.delete();
    key_pool.push_back('0);
    key_pool.push_back('1);
    while (key_pool.size() < size)
      key_pool.push_back($urandom());
  endfunction

  // Random mix of ticks, fresh keys and keys drawn from a reused pool.
  task automatic run_mix(int n_items, int tick_pct, int fresh_pct, int pool_size);
    int r;
    build_pool(pool_size);
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct)
        send_req(KIND_TICK, $urandom());
      else if ($urandom_range(0, 99) < fresh_pct)
        send_req(KIND_LOOKUP, $urandom());
      else
        send_req(KIND_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
      if ($urandom_range(0, 49) == 0)
        drain_results();
    end
  endtask

  task automatic test_register_reset();
    check_reg(REG_LIMIT);
    check_reg(REG_PERIOD);
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    // Extreme keys, a hit, and a tick well short of the period.
    send_req(KIND_LOOKUP, 32'h0000_0000);
    send_req(KIND_LOOKUP, 32'hFFFF_FFFF);
    send_req(KIND_LOOKUP, 32'h0000_0000);
    send_req(KIND_TICK, 32'hFFFF_FFFF);
    send_req(KIND_LOOKUP, 32'h8000_0001);
    // Cleaning on every tick with a limit of one evicts the two cold entries.
    set_config(7'd1, 16'd1);
    send_req(KIND_TICK, 32'h0000_0000);
    // A limit above the occupancy ages the table but evicts nothing.
    set_config(7'd64, 16'd1);
    send_req(KIND_TICK, 32'h5555_AAAA);
    send_req(KIND_LOOKUP, 32'h0000_0000);
    // A period of zero cleans on every tick, like a period of one.
    set_config(7'd64, 16'd0);
    send_req(KIND_TICK, 32'hAAAA_5555);
    send_req(KIND_LOOKUP, 32'h0000_0005);
    send_req(KIND_LOOKUP, 32'h0000_0006);
    send_req(KIND_LOOKUP, 32'h0000_0007);
    // A limit of zero empties the table, last set only on the final eviction.
    set_config(7'd0, 16'd0);
    send_req(KIND_TICK, 32'h1234_5678);
    send_req(KIND_LOOKUP, 32'h0000_0000);
    set_config(7'd64, 16'd2000);
  endtask

  // Key zero sits in slot zero, so each hit is quick; hit it back to back.
  task automatic test_hit_burst();
    idle_on = 1'b0;
    set_config(7'd64, 16'hFFFF);
    repeat (16) send_req(KIND_LOOKUP, 32'h0000_0000);
  endtask

  task automatic test_fill_overflow();
    idle_on = 1'b1;
    set_config(7'd64, 16'd1000);
    run_mix(90, 3, 92, 16);
  endtask

  task automatic test_heavy_eviction();
    idle_on = 1'b1;
    set_config(LIMIT_W'($urandom_range(0, 16)), 16'd1);
    run_mix(25, 30, 60, 16);
  endtask

  task automatic test_aging_mix();
    idle_on = 1'b1;
    set_config(LIMIT_W'($urandom_range(8, 40)), PERIOD_W'($urandom_range(2, 6)));
    run_mix(60, 20, 10, 48);
  endtask

  task automatic test_long_period();
    idle_on = 1'b0;
    set_config(7'd127, 16'hFFFF);
    run_mix(30, 10, 50, 24);
  endtask

  task automatic test_config_sweep();
    logic [PERIOD_W-1:0] period;
    idle_on = 1'b1;
    for (int seg = 0; seg < 4; seg++) begin
      period = (seg == 0) ? PERIOD_W'($urandom()) : PERIOD_W'($urandom_range(0, 6));
      set_config(LIMIT_W'($urandom_range(0, 127)), period);
      run_mix(10, 30, 30, 24);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_directed_cases();
    test_hit_burst();
    test_fill_overflow();
    test_heavy_eviction();
    test_aging_mix();
    test_long_period();
    test_config_sweep();
    drain_results();
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
